FILE: hw/rtl/dma_pkg.sv
// ----------------------------------------------------------------------------
// dma_pkg
// shared widths, register indexes, item types and constants of the
// difference matte alpha unit
// ----------------------------------------------------------------------------
package dma_pkg;

    localparam int CHANNEL_BITS = 16;

    // sum of three absolute channel differences
    localparam int SUM_W = CHANNEL_BITS + 2;

    // divide by three as multiply by ceil(2^k / 3) and shift by k
    localparam int DIV3_SHIFT = SUM_W + 1;
    localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int PROD_W     = SUM_W + DIV3_SHIFT;

    localparam int NUM_IN_FIELDS = 7;
    localparam int IN_TDATA_W    = ((NUM_IN_FIELDS * CHANNEL_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((CHANNEL_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FALLOFF   = 1'b1;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    typedef struct packed {
        chan_t image_red;
        chan_t image_green;
        chan_t image_blue;
        chan_t image_alpha;
        chan_t key_red;
        chan_t key_green;
        chan_t key_blue;
    } dma_pixel_t;

    // how the alpha of an item is finally formed
    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_RAMP = 2'd1,
        CLS_PASS = 2'd2
    } dma_class_t;

    typedef struct packed {
        dma_class_t cls;
        chan_t      alpha;
        chan_t      rem;
        chan_t      quot;
    } dma_item_t;

endpackage

FILE: hw/rtl/dma_front.sv
// ----------------------------------------------------------------------------
// dma_front
// four-stage front end: channel differences, sum, divide by three,
// classification against tolerance and falloff band
// ----------------------------------------------------------------------------
module dma_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  dma_pkg::dma_pixel_t             pixel,
    input  logic [dma_pkg::CHANNEL_BITS-1:0] tolerance,
    input  logic [dma_pkg::CHANNEL_BITS-1:0] falloff,
    output logic                            out_valid,
    output dma_pkg::dma_item_t              item
);
    import dma_pkg::*;

    localparam int STAGES = 4;

    logic [STAGES-1:0] valid_reg;

    chan_t             diff_r_reg;
    chan_t             diff_g_reg;
    chan_t             diff_b_reg;
    chan_t             alpha1_reg;
    logic [SUM_W-1:0]  sum_reg;
    chan_t             alpha2_reg;
    logic [PROD_W-1:0] prod_reg;
    chan_t             alpha3_reg;
    dma_item_t         item_reg;

    chan_t               diff3;
    logic [CHANNEL_BITS:0] band_end;
    dma_item_t           item_next;

    function automatic chan_t abs_diff(input chan_t a, input chan_t b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        diff3    = prod_reg[DIV3_SHIFT +: CHANNEL_BITS];
        band_end = {1'b0, tolerance} + {1'b0, falloff};
        item_next.alpha = alpha3_reg;
        item_next.rem   = diff3 - tolerance;
        item_next.quot  = '0;
        if (diff3 < tolerance)
        begin
            item_next.cls = CLS_ZERO;
        end
        else if ({1'b0, diff3} < band_end)
        begin
            item_next.cls = CLS_RAMP;
        end
        else
        begin
            item_next.cls = CLS_PASS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_r_reg <= abs_diff(pixel.key_red, pixel.image_red);
            diff_g_reg <= abs_diff(pixel.key_green, pixel.image_green);
            diff_b_reg <= abs_diff(pixel.key_blue, pixel.image_blue);
            alpha1_reg <= pixel.image_alpha;

            sum_reg    <= SUM_W'(diff_r_reg) + SUM_W'(diff_g_reg) + SUM_W'(diff_b_reg);
            alpha2_reg <= alpha1_reg;

            prod_reg   <= PROD_W'(sum_reg) * PROD_W'(DIV3_MUL);
            alpha3_reg <= alpha2_reg;

            item_reg   <= item_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign item      = item_reg;

endmodule

FILE: hw/rtl/dma_divider.sv
// ----------------------------------------------------------------------------
// dma_divider
// pipelined restoring divider: one quotient bit per stage, computes
// rem * 2^CHANNEL_BITS / falloff for items in the falloff band
// ----------------------------------------------------------------------------
module dma_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  dma_pkg::dma_item_t               in_item,
    input  logic [dma_pkg::CHANNEL_BITS-1:0] falloff,
    output logic                             out_valid,
    output dma_pkg::dma_item_t               out_item
);
    import dma_pkg::*;

    localparam int STAGES = CHANNEL_BITS;

    logic [STAGES-1:0] valid_reg;
    dma_item_t         stage_reg [STAGES];

    // partial remainder stays below falloff, so it fits the channel width
    function automatic dma_item_t div_step(input dma_item_t src, input chan_t den);
        logic [CHANNEL_BITS:0] shifted;
        logic                  take;
        dma_item_t             res;
        shifted = {src.rem, 1'b0};
        take    = (shifted >= {1'b0, den});
        res     = src;
        res.rem = take ? CHANNEL_BITS'(shifted - {1'b0, den})
                       : shifted[CHANNEL_BITS-1:0];
        res.quot = {src.quot[CHANNEL_BITS-2:0], take};
        div_step = res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= div_step(in_item, falloff);
        end
    end

    for (genvar i = 1; i < STAGES; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[i] <= div_step(stage_reg[i-1], falloff);
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_item  = stage_reg[STAGES-1];

endmodule

FILE: hw/rtl/difference_matte_alpha_unit.sv
// ----------------------------------------------------------------------------
// difference_matte_alpha_unit
// difference key matte: alpha from the distance between image and key color
// ----------------------------------------------------------------------------
// Takes one pixel item (image RGBA and key RGB) per clock, unless stalled, and
// returns one matte alpha item per pixel, in order. An item passes 21 register
// stages: 4 front-end stages (differences, sum, divide by three, band compare),
// CHANNEL_BITS = 16 divider stages that each resolve one bit of the falloff
// ramp quotient, and the output register. A two-entry output buffer keeps the
// pipeline moving while one result waits; the input stalls only when both
// entries are full. The user must write tolerance and falloff through
// cfg_we/cfg_index/cfg_data only while no item is in flight; the block itself
// does not enforce it.
module difference_matte_alpha_unit (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // image_red, image_green, image_blue, image_alpha, key_red, key_green, key_blue
    input  logic [dma_pkg::IN_TDATA_W-1:0]    s_axis_tdata,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // matte_alpha
    output logic [dma_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,

    input  logic                              cfg_we,
    input  logic [dma_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dma_pkg::CHANNEL_BITS-1:0]  cfg_data
);
    import dma_pkg::*;

    chan_t      tolerance_reg;
    chan_t      falloff_reg;

    logic       en;
    dma_pixel_t pixel;
    logic       front_valid;
    dma_item_t  front_item;
    logic       div_valid;
    dma_item_t  div_item;
    chan_t      result_next;
    logic       load;

    logic       out_valid_reg;
    chan_t      out_data_reg;
    logic       skid_valid_reg;
    chan_t      skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= '0;
            falloff_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOLERANCE: tolerance_reg <= cfg_data;
                REG_FALLOFF:   falloff_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign pixel.image_red   = s_axis_tdata[0*CHANNEL_BITS +: CHANNEL_BITS];
    assign pixel.image_green = s_axis_tdata[1*CHANNEL_BITS +: CHANNEL_BITS];
    assign pixel.image_blue  = s_axis_tdata[2*CHANNEL_BITS +: CHANNEL_BITS];
    assign pixel.image_alpha = s_axis_tdata[3*CHANNEL_BITS +: CHANNEL_BITS];
    assign pixel.key_red     = s_axis_tdata[4*CHANNEL_BITS +: CHANNEL_BITS];
    assign pixel.key_green   = s_axis_tdata[5*CHANNEL_BITS +: CHANNEL_BITS];
    assign pixel.key_blue    = s_axis_tdata[6*CHANNEL_BITS +: CHANNEL_BITS];

    // whole pipeline advances while the skid entry is free
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    dma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .pixel     (pixel),
        .tolerance (tolerance_reg),
        .falloff   (falloff_reg),
        .out_valid (front_valid),
        .item      (front_item)
    );

    dma_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .falloff   (falloff_reg),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    always_comb
    begin
        case (div_item.cls)
            CLS_ZERO: result_next = '0;
            CLS_RAMP: result_next = (div_item.quot < div_item.alpha) ? div_item.quot
                                                                     : div_item.alpha;
            CLS_PASS: result_next = div_item.alpha;
            default:  result_next = div_item.alpha;
        endcase
    end

    assign load = div_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= load;
            end
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result_next;
        end
        else if (load)
        begin
            skid_data_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

    // the skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while the output register is empty");

    // an item classed into the band implies a nonzero falloff for the divider
    a_ramp_needs_falloff: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && front_item.cls == CLS_RAMP) |-> falloff_reg != '0)
        else $error("band item with zero falloff");

    // the skid entry drains only into a taken output register
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_valid_reg) |-> $past(m_axis_tready))
        else $error("skid entry dropped without the output being taken");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the difference matte alpha unit
// ----------------------------------------------------------------------------
// Streams image/key pixel items through the unit under several tolerance and
// falloff settings, extremes included, and holds a bit-exact matte predictor
// in a small scoreboard. Directed pixels sit on the band edges first, then
// random pixels follow, mostly placed around the ramp band. Both stream sides
// idle at random, and one long output stall backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_top;
    import dma_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 150;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 66;
    localparam int MAX_SUM        = 3 * 65535;

    class matte_scoreboard;
        chan_t tol;
        chan_t fall;
        chan_t alpha_q[$];
        int    errors;
        int    checked;
        int    hits[3];

        function new();
            tol     = '0;
            fall    = '0;
            errors  = 0;
            checked = 0;
            hits    = '{0, 0, 0};
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, chan_t value);
            if (idx == REG_TOLERANCE)
                tol = value;
            else if (idx == REG_FALLOFF)
                fall = value;
        endfunction

        function automatic chan_t abs_gap(chan_t a, chan_t b);
            return (a > b) ? a - b : b - a;
        endfunction

        // expected matte alpha of one accepted pixel
        function void note_pixel(dma_pixel_t p);
            logic [17:0] sum;
            chan_t       diff;
            logic [16:0] band_end;
            logic [31:0] ramp;
            chan_t       alpha;
            dma_class_t  cls;
            sum = abs_gap(p.key_red, p.image_red) + abs_gap(p.key_green, p.image_green)
                + abs_gap(p.key_blue, p.image_blue);
            diff = 16'(sum / 3);
            // band end may pass the largest fraction, so keep the carry
            band_end = {1'b0, tol} + {1'b0, fall};
            if (diff < tol) begin
                alpha = '0;
                cls   = CLS_ZERO;
            end
            else if ({1'b0, diff} < band_end) begin
                ramp  = {diff - tol, 16'h0000} / {16'h0000, fall};
                alpha = (ramp < {16'h0000, p.image_alpha}) ? ramp[15:0] : p.image_alpha;
                cls   = CLS_RAMP;
            end
            else begin
                alpha = p.image_alpha;
                cls   = CLS_PASS;
            end
            hits[cls]++;
            alpha_q.push_back(alpha);
        endfunction

        function void report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endfunction

        function void check_alpha(chan_t got);
            chan_t want;
            if (alpha_q.size() == 0) begin
                report($sformatf("matte alpha %h arrived with none outstanding", got));
                return;
            end
            want = alpha_q.pop_front();
            checked++;
            if (got !== want)
                report($sformatf("result %0d: matte alpha %h, expected %h", checked, got, want));
        endfunction

        function int pending();
            return alpha_q.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // image_red, image_green, image_blue, image_alpha, key_red, key_green, key_blue
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // matte_alpha
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CHANNEL_BITS-1:0] cfg_data;

    matte_scoreboard sb;
    bit              no_gaps   = 1'b0;
    bit              hold_long = 1'b0;
    int              sent      = 0;
    int              settings  = 0;
    int              idle_cycles = 0;

    difference_matte_alpha_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // first field in the lowest bits
    function automatic logic [IN_TDATA_W-1:0] pack_pixel(dma_pixel_t p);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[7*CHANNEL_BITS-1:0] = {p.key_blue, p.key_green, p.key_red, p.image_alpha,
                                 p.image_blue, p.image_green, p.image_red};
        return d;
    endfunction

    function automatic void spread(int unsigned gap, output chan_t img, output chan_t key);
        int unsigned base;
        base = $urandom_range(65535 - gap, 0);
        if ($urandom_range(1, 0)) begin
            img = 16'(base);
            key = 16'(base + gap);
        end
        else begin
            key = 16'(base);
            img = 16'(base + gap);
        end
    endfunction

    // random colors whose truncated distance is exactly d
    function automatic dma_pixel_t pixel_at(int unsigned d, chan_t alpha);
        int unsigned s;
        int unsigned d1;
        int unsigned d2;
        int unsigned rest;
        dma_pixel_t  p;
        s = 3 * d + $urandom_range(2, 0);
        if (s > MAX_SUM)
            s = MAX_SUM;
        d1 = $urandom_range((s > 65535) ? 65535 : s, (s > 131070) ? s - 131070 : 0);
        rest = s - d1;
        d2 = $urandom_range((rest > 65535) ? 65535 : rest, (rest > 65535) ? rest - 65535 : 0);
        spread(d1, p.image_red, p.key_red);
        spread(d2, p.image_green, p.key_green);
        spread(rest - d2, p.image_blue, p.key_blue);
        p.image_alpha = alpha;
        return p;
    endfunction

    function automatic dma_pixel_t random_pixel(chan_t tol, chan_t fall);
        int unsigned           pick;
        int unsigned           lo;
        int unsigned           hi;
        int unsigned           a;
        chan_t                 alpha;
        logic [127:0]          raw;
        pick = $urandom_range(99, 0);
        a    = $urandom_range(9, 0);
        alpha = (a == 0) ? 16'h0000 : (a == 1) ? 16'hFFFF : 16'($urandom);
        if (pick < 10) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            return raw[$bits(dma_pixel_t)-1:0];
        end
        if (pick < 30)
            return pixel_at($urandom_range(65535, 0), alpha);
        // most pixels land around the ramp band
        lo = (tol >= 256) ? tol - 256 : 0;
        hi = tol + fall + 256;
        if (hi > 65535)
            hi = 65535;
        return pixel_at($urandom_range(hi, lo), alpha);
    endfunction

    task automatic send_pixel(dma_pixel_t p);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(9, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_pixel(p);
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_pixel(p);
        sent++;
    endtask

    // registers change only once the pipeline has drained
    task automatic set_matte(chan_t tol, chan_t fall);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TOLERANCE;
        cfg_data  <= tol;
        @(posedge clk);
        sb.set_reg(REG_TOLERANCE, tol);
        cfg_index <= REG_FALLOFF;
        cfg_data  <= fall;
        @(posedge clk);
        sb.set_reg(REG_FALLOFF, fall);
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin : sink
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_long) begin
                stall     = LONG_HOLD;
                hold_long = 1'b0;
            end
            else
                stall = no_gaps ? 0 : $urandom_range(9, 0);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            sb.check_alpha(m_axis_tdata[CHANNEL_BITS-1:0]);
        end
    end

    initial
    begin : stimulus
        int    ph;
        int    i;
        chan_t t;
        chan_t f;
        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_TOLERANCE;
        cfg_data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty band, everything keeps its alpha
        send_pixel('0);
        send_pixel('1);
        send_pixel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0});

        // band edges, ramp midpoint and the alpha cap
        set_matte(16'h1000, 16'h0800);
        send_pixel(pixel_at(16'h0FFF, 16'hFFFF));
        send_pixel(pixel_at(16'h1000, 16'hFFFF));
        send_pixel(pixel_at(16'h1001, 16'hFFFF));
        send_pixel(pixel_at(16'h1400, 16'hFFFF));
        send_pixel(pixel_at(16'h1400, 16'h1234));
        send_pixel(pixel_at(16'h1400, 16'h0000));
        send_pixel(pixel_at(16'h17FF, 16'hFFFF));
        send_pixel(pixel_at(16'h1800, 16'h5555));
        send_pixel(pixel_at(0, 16'hFFFF));
        send_pixel(pixel_at(65535, 16'h0000));

        // widest band from zero
        set_matte(16'h0000, 16'hFFFF);
        send_pixel(pixel_at(0, 16'hFFFF));
        send_pixel(pixel_at(65534, 16'hFFFF));
        send_pixel(pixel_at(65535, 16'hABCD));

        // band end beyond the largest fraction
        set_matte(16'hFFFF, 16'hFFFF);
        send_pixel(pixel_at(65534, 16'hFFFF));
        send_pixel(pixel_at(65535, 16'hFFFF));

        // zero falloff: no ramp at all
        set_matte(16'hFFFF, 16'h0000);
        send_pixel(pixel_at(65535, 16'h8001));
        send_pixel(pixel_at(65534, 16'h8001));

        // one-step band
        set_matte(16'h8000, 16'h0001);
        send_pixel(pixel_at(16'h8000, 16'hFFFF));
        send_pixel(pixel_at(16'h8001, 16'h7FFE));

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin t = 16'h2000;     f = 16'h4000;                    end
                1: begin t = 16'h0000;     f = 16'hFFFF;                    end
                2: begin t = 16'hFFFF;     f = 16'hFFFF;                    end
                3: begin t = 16'($urandom); f = 16'h0000;                   end
                4, 5: begin t = 16'($urandom); f = 16'($urandom_range(2048, 1)); end
                default: begin t = 16'($urandom); f = 16'($urandom);         end
            endcase
            set_matte(t, f);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // back-to-back stretch, and in one phase a long output stall
                no_gaps = (i >= 20 && i < 36) || (ph == 1 && i >= 40);
                if (ph == 1 && i == 40)
                    hold_long = 1'b1;
                send_pixel(random_pixel(sb.tol, sb.fall));
            end
            no_gaps = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (30) @(posedge clk);

        $display("covered %0d pixels under %0d matte settings, %0d results checked",
                 sent, settings, sb.checked);
        $display("keyed out %0d, on the ramp %0d, alpha kept %0d, mismatches %0d",
                 sb.hits[CLS_ZERO], sb.hits[CLS_RAMP], sb.hits[CLS_PASS], sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
